@@ sv/wat_pkg.sv @@
// ---------------------------------------------------------------------------
// Weekday alarm table package
// Shared types, field codes and widths for the alarm table block.
// ---------------------------------------------------------------------------
`default_nettype none

package wat_pkg;

  // Default number of alarm slots.
  localparam int unsigned SlotsDefault = 16;

  // Field widths.
  localparam int unsigned IdW     = 63;
  localparam int unsigned InDataW = 104;  // 101 field bits padded to whole bytes
  localparam int unsigned OutDataW = 72;  // 66 field bits padded to whole bytes

  // Input item kinds.
  localparam logic [1:0] KindAdd  = 2'd0;
  localparam logic [1:0] KindDel  = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;
  localparam logic [1:0] KindNone = 2'd3;

  // Alarm actions.
  localparam logic [2:0] ActDelete   = 3'd0;
  localparam logic [2:0] ActAdd      = 3'd1;
  localparam logic [2:0] ActDisabled = 3'd3;
  localparam logic [2:0] ActEdit     = 3'd4;

  // Result event codes.
  localparam logic [1:0] EvStatus = 2'd0;
  localparam logic [1:0] EvPlay   = 2'd1;
  localparam logic [1:0] EvTick   = 2'd2;

  // Indicator drive codes.
  localparam logic [1:0] LedOff   = 2'd0;
  localparam logic [1:0] LedGreen = 2'd1;
  localparam logic [1:0] LedKeep  = 2'd2;

  // The last minute of the day, when fired marks are cleared.
  localparam logic [4:0] LastHour   = 5'd23;
  localparam logic [5:0] LastMinute = 6'd59;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] alarm_id;
    logic [2:0]     action;
    logic [4:0]     alarm_hour;
    logic [5:0]     alarm_minute;
    logic [6:0]     day_mask;
    logic           repeat_alarm;
    logic           setting_well_formed;
    logic [4:0]     now_hour;
    logic [5:0]     now_minute;
    logic [2:0]     now_weekday;
    logic           player_free;
  } item_t;

  // One stored alarm entry.
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [2:0]     action;
    logic [4:0]     hour;
    logic [5:0]     minute;
    logic [6:0]     days;
    logic           fired;
    logic           rpt;
    logic           well;
  } slot_entry_t;

  // One result word.
  typedef struct packed {
    logic [1:0]     ev;
    logic [IdW-1:0] fired_id;
    logic           table_full;
    logic [1:0]     led;
    logic           last;
  } result_t;

endpackage

`default_nettype wire

@@ sv/weekday_alarm_table.sv @@
// ---------------------------------------------------------------------------
// Weekday alarm table
// Alarm table with add, edit and delete by ID and a per-minute firing scan.
// ---------------------------------------------------------------------------
// Usage: items arrive as words on the s_axis channel; tuser carries the kind
// (add or edit, delete, clock tick) and tdata the alarm setting and the clock.
// Results leave as words on the m_axis channel; tuser carries the event code
// and tlast marks the final word for an item.
//
// Every add, delete or tick is accepted while the first read issues; the
// sequencer then walks the slot memory slot by slot through its single
// registered read port and closes with a status or tick word. An item of
// unknown kind is accepted and dropped without a scan. A tick emits a play
// word for each alarm that fires while the player is free; the scan holds on
// that slot whenever the output register cannot take the word.
//
// Reset clears the used and written marks of every slot, so the table starts
// empty at once; no clearing pass runs. A stalled receiver stalls only the
// output register and, through it, the scan; the input is taken again once
// the closing word has entered the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module weekday_alarm_table #(
  parameter int unsigned Slots = wat_pkg::SlotsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input words.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata from bit 0: alarm_id[62:0], action[65:63], alarm_hour[70:66],
  // alarm_minute[76:71], day_mask[83:77], repeat_alarm[84],
  // setting_well_formed[85], now_hour[90:86], now_minute[96:91],
  // now_weekday[99:97], player_free[100], zero padding[103:101].
  input  wire [wat_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: kind[1:0].
  input  wire [1:0]                    s_axis_tuser,
  // Result words.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // tdata from bit 0: fired_id[62:0], table_full[63], led_drive[65:64],
  // zero padding[71:66].
  output logic [wat_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: event_res[1:0].
  output logic [1:0]                   m_axis_tuser,
  // tlast: last_result.
  output logic                         m_axis_tlast
);
  import wat_pkg::*;

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;

  item_t           item;
  logic            mem_wr_en, mem_rd_en;
  logic [IdxW-1:0] mem_wr_addr, mem_rd_addr;
  slot_entry_t     mem_wr_data, mem_rd_data;
  logic            res_valid, res_ready;
  result_t         res, out_res;

  // Unpack the input word into its fields.
  assign item.kind                = s_axis_tuser;
  assign item.alarm_id            = s_axis_tdata[62:0];
  assign item.action              = s_axis_tdata[65:63];
  assign item.alarm_hour          = s_axis_tdata[70:66];
  assign item.alarm_minute        = s_axis_tdata[76:71];
  assign item.day_mask            = s_axis_tdata[83:77];
  assign item.repeat_alarm        = s_axis_tdata[84];
  assign item.setting_well_formed = s_axis_tdata[85];
  assign item.now_hour            = s_axis_tdata[90:86];
  assign item.now_minute          = s_axis_tdata[96:91];
  assign item.now_weekday         = s_axis_tdata[99:97];
  assign item.player_free         = s_axis_tdata[100];

  wat_seq #(
    .Slots (Slots),
    .IdxW  (IdxW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .wr_en_o     (mem_wr_en),
    .wr_addr_o   (mem_wr_addr),
    .wr_data_o   (mem_wr_data),
    .rd_en_o     (mem_rd_en),
    .rd_addr_o   (mem_rd_addr),
    .rd_data_i   (mem_rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The slot memory holds every stored alarm field except the used marks.
  wat_mem #(
    .Slots (Slots),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // The output register decouples the result channel from the scan.
  wat_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // Pack the result word.
  assign m_axis_tdata = {6'd0, out_res.led, out_res.table_full, out_res.fired_id};
  assign m_axis_tuser = out_res.ev;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

@@ sv/wat_mem.sv @@
// ---------------------------------------------------------------------------
// Weekday alarm table slot memory
// One write port and one registered read port over the alarm entries.
// ---------------------------------------------------------------------------
`default_nettype none

module wat_mem #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire                       clk_i,
  input  wire                       wr_en_i,
  input  wire [IdxW-1:0]            wr_addr_i,
  input  wat_pkg::slot_entry_t      wr_data_i,
  input  wire                       rd_en_i,
  input  wire [IdxW-1:0]            rd_addr_i,
  output wat_pkg::slot_entry_t      rd_data_o
);
  import wat_pkg::*;

  slot_entry_t mem_q [Slots];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/wat_obuf.sv @@
// ---------------------------------------------------------------------------
// Weekday alarm table output register
// Holds one result word until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module wat_obuf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wat_pkg::result_t    res_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output wat_pkg::result_t    res_o
);
  import wat_pkg::*;

  logic    valid_q;
  result_t data_q;

  // A new word may enter when the register is empty or is being emptied.
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

`default_nettype wire

@@ sv/wat_seq.sv @@
// ---------------------------------------------------------------------------
// Weekday alarm table sequencer
// Walks the slot memory once per add, delete or tick item and applies its updates.
// ---------------------------------------------------------------------------
`default_nettype none

module wat_seq #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wat_pkg::item_t        item_i,
  output logic                  wr_en_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output wat_pkg::slot_entry_t  wr_data_o,
  output logic                  rd_en_o,
  output logic [IdxW-1:0]       rd_addr_o,
  input  wat_pkg::slot_entry_t  rd_data_i,
  output logic                  res_valid_o,
  input  wire                   res_ready_i,
  output wat_pkg::result_t      res_o
);
  import wat_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  state_e            state_q, state_d;
  item_t             item_q;
  logic [IdxW-1:0]   idx_q;
  logic [Slots-1:0]  used_q, used_d;
  logic [Slots-1:0]  wrtn_q, wrtn_d;
  logic              any_q;
  logic              match_q, free_q;
  logic [IdxW-1:0]   match_idx_q, free_idx_q;
  logic [2:0]        match_act_q, free_act_q;

  logic              accept;
  logic              is_del, is_add, is_tick;
  logic              cur_used, id_hit, act_ok, drop, at_midnight;
  logic              fired_kept, day_hit, fire, emit_play, advance, done_go;
  logic [2:0]        cur_act, wd_m1, new_act, sel_act;
  logic [7:0]        days8;
  logic [IdxW-1:0]   sel_idx;
  logic              sel_ok;
  slot_entry_t       ent;

  assign ent        = rd_data_i;
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign is_del  = (item_q.kind == KindDel) ||
                   (item_q.kind == KindAdd && item_q.action == ActDelete);
  assign is_add  = (item_q.kind == KindAdd) && (item_q.action != ActDelete);
  assign is_tick = (item_q.kind == KindTick);

  // Per-slot decisions on the entry held in the memory's read register.
  assign cur_used = used_q[idx_q];
  assign cur_act  = wrtn_q[idx_q] ? ent.action : ActDelete;
  assign id_hit   = cur_used && (ent.id == item_q.alarm_id);

  assign act_ok      = (ent.action >= ActAdd) && (ent.action <= ActEdit);
  assign drop        = act_ok && ((ent.action == ActDisabled) || !ent.well);
  assign at_midnight = (item_q.now_hour == LastHour) && (item_q.now_minute == LastMinute);
  assign fired_kept  = ent.fired && !at_midnight;
  assign wd_m1       = item_q.now_weekday - 3'd1;
  assign days8       = {1'b0, ent.days};
  // Weekday zero wraps to the padding bit, so only an empty mask matches it.
  assign day_hit     = (ent.days == 7'd0) || days8[wd_m1];
  assign fire        = act_ok && !drop && day_hit && !fired_kept &&
                       (ent.hour == item_q.now_hour) && (ent.minute == item_q.now_minute);
  assign emit_play   = (state_q == StScan) && is_tick && cur_used && fire &&
                       item_q.player_free;
  assign advance     = (state_q == StScan) && (!emit_play || res_ready_i);
  assign done_go     = (state_q == StDone) && res_ready_i;

  // Slot chosen by an add: the entry with the same ID, else the first free one.
  assign sel_ok  = match_q || free_q;
  assign sel_idx = match_q ? match_idx_q : free_idx_q;
  assign sel_act = match_q ? match_act_q : free_act_q;
  assign new_act = (item_q.action == ActEdit) ? sel_act : item_q.action;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    wrtn_d    = wrtn_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = ent;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q + IdxW'(1);
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      StIdle: begin
        if (accept && item_i.kind != KindNone) begin
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          state_d   = StScan;
        end
      end
      StScan: begin
        res_valid_o       = emit_play;
        res_o.ev          = EvPlay;
        res_o.fired_id    = ent.id;
        res_o.led         = LedKeep;
        if (advance) begin
          if (is_del && id_hit) begin
            used_d[idx_q] = 1'b0;
          end
          if (is_tick && cur_used && act_ok) begin
            if (drop || (fire && !ent.rpt)) begin
              used_d[idx_q] = 1'b0;
            end
            if (!drop) begin
              wr_en_o         = 1'b1;
              wr_data_o.fired = fired_kept || fire;
            end
          end
          if (idx_q == LastIdx) begin
            state_d = StDone;
          end else begin
            rd_en_o = 1'b1;
          end
        end
      end
      StDone: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (is_tick) begin
          res_o.ev  = EvTick;
          res_o.led = any_q ? LedGreen : LedOff;
        end else if (is_del) begin
          res_o.ev  = EvStatus;
          res_o.led = LedOff;
        end else begin
          res_o.ev         = EvStatus;
          res_o.table_full = !sel_ok;
          res_o.led        = (item_q.action != ActDisabled) ? LedGreen : LedKeep;
        end
        wr_addr_o = sel_idx;
        wr_data_o = '{id: item_q.alarm_id, action: new_act, hour: item_q.alarm_hour,
                      minute: item_q.alarm_minute, days: item_q.day_mask, fired: 1'b0,
                      rpt: item_q.repeat_alarm, well: item_q.setting_well_formed};
        if (done_go) begin
          if (is_add && sel_ok) begin
            wr_en_o         = 1'b1;
            used_d[sel_idx] = 1'b1;
            wrtn_d[sel_idx] = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q  <= '0;
      wrtn_q  <= '0;
      idx_q   <= '0;
      any_q   <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      wrtn_q  <= wrtn_d;
      if (accept) begin
        idx_q   <= '0;
        any_q   <= 1'b0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (advance) begin
        idx_q <= idx_q + IdxW'(1);
        if (cur_used) begin
          any_q <= 1'b1;
        end
        if (id_hit && !match_q) begin
          match_q <= 1'b1;
        end
        if (!cur_used && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (advance && id_hit && !match_q) begin
      match_idx_q <= idx_q;
      match_act_q <= ent.action;
    end
    if (advance && !cur_used && !free_q) begin
      free_idx_q <= idx_q;
      free_act_q <= cur_act;
    end
  end

`ifndef SYNTH
  a_play_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.ev == EvPlay) |-> (state_q == StScan && item_q.kind == KindTick))
    else $error("play result outside a tick scan");

  a_last_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> (state_q == StDone))
    else $error("final result outside the done step");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind != KindNone) |=> (state_q == StScan && idx_q == '0))
    else $error("accepted item did not start a scan at slot zero");

  a_idle_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |=> $stable(used_q))
    else $error("slot usage changed while idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (idx_q <= LastIdx))
    else $error("scan index beyond the last slot");
`endif

endmodule

`default_nettype wire

@@ test/weekday_alarm_table_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Weekday alarm table testbench
// Drives add, edit, delete and clock tick words into the alarm table and
// checks every result word against a typed expectation or a behavioural model of the table.
// ---------------------------------------------------------------------------

module weekday_alarm_table_tb;
  import wat_pkg::*;

  localparam int unsigned Slots       = SlotsDefault;
  localparam int unsigned RandomWords = 250;
  // The closing stretch of the random part runs without any idling.
  localparam int unsigned CalmWords   = 40;
  localparam int unsigned MaxReports  = 40;
  // Actions that the package leaves unnamed: switched on, and one of the
  // codes above the edit code that the table stores but never schedules.
  localparam logic [2:0]     ActOn    = 3'd2;
  localparam logic [2:0]     ActStray = 3'd7;
  localparam logic [IdW-1:0] IdTop    = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  weekday_alarm_table #(
    .Slots(Slots)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Model of the table: the stored entries, their occupancy, and the result
  // words still owed by the block, oldest first.
  slot_entry_t alarm_mem [Slots];
  bit          slot_taken [Slots];
  result_t     events_due [$];

  // Small pools of IDs and clock times, so that adds, deletes and ticks keep
  // meeting the entries already in the table.
  logic [IdW-1:0] id_pool [8];
  logic [4:0]     hour_pool [4];
  logic [5:0]     minute_pool [4];

  // Idling level shared by both sides (0 none, 3 heavy); calm stops it.
  int unsigned idle_level = 0;
  bit          calm = 1'b0;

  int unsigned n_mismatch = 0;
  int unsigned n_results  = 0;
  int unsigned n_plays    = 0;
  int unsigned n_adds     = 0;
  int unsigned n_deletes  = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_ignored  = 0;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } script_row_t;

  function automatic result_t make_event(logic [1:0] ev, logic [IdW-1:0] id, logic full,
                                         logic [1:0] led, logic last);
    result_t r;
    r.ev         = ev;
    r.fired_id   = id;
    r.table_full = full;
    r.led        = led;
    r.last       = last;
    return r;
  endfunction

  function automatic item_t alarm_item(logic [1:0] kind, logic [IdW-1:0] id, logic [2:0] act,
                                       logic [4:0] hh, logic [5:0] mm, logic [6:0] days,
                                       logic rpt, logic well);
    item_t it;
    it                     = '0;
    it.kind                = kind;
    it.alarm_id            = id;
    it.action              = act;
    it.alarm_hour          = hh;
    it.alarm_minute        = mm;
    it.day_mask            = days;
    it.repeat_alarm        = rpt;
    it.setting_well_formed = well;
    return it;
  endfunction

  function automatic item_t tick_item(logic [4:0] hh, logic [5:0] mm, logic [2:0] wd,
                                      logic pfree);
    item_t it;
    it             = '0;
    it.kind        = KindTick;
    it.now_hour    = hh;
    it.now_minute  = mm;
    it.now_weekday = wd;
    it.player_free = pfree;
    return it;
  endfunction

  function automatic logic [IdW-1:0] fresh_id();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[IdW-1:0];
  endfunction

  // Freeing an alarm frees every used entry that carries its ID.
  function automatic void drop_alarm(logic [IdW-1:0] id);
    for (int i = 0; i < Slots; i++)
      if (slot_taken[i] && alarm_mem[i].id == id) slot_taken[i] = 1'b0;
  endfunction

  // Works out the result words of one accepted word and updates the model.
  function automatic void predict_events(item_t it);
    int         slot;
    logic [2:0] act;
    logic [1:0] led;
    bit         any_used;
    bit         day_hit;
    slot     = -1;
    any_used = 1'b0;
    if (it.kind == KindDel || (it.kind == KindAdd && it.action == ActDelete)) begin
      // An add carrying the delete action behaves as a delete.
      drop_alarm(it.alarm_id);
      events_due.push_back(make_event(EvStatus, '0, 1'b0, LedOff, 1'b1));
    end else if (it.kind == KindAdd) begin
      led = (it.action != ActDisabled) ? LedGreen : LedKeep;
      // An entry with the same ID is overwritten, else the lowest free slot.
      for (int i = 0; i < Slots; i++)
        if (slot < 0 && slot_taken[i] && alarm_mem[i].id == it.alarm_id) slot = i;
      for (int i = 0; i < Slots; i++)
        if (slot < 0 && !slot_taken[i]) slot = i;
      if (slot < 0) begin
        events_due.push_back(make_event(EvStatus, '0, 1'b1, led, 1'b1));
      end else begin
        // An edit keeps whatever action the slot still holds, even a freed one.
        act = (it.action == ActEdit) ? alarm_mem[slot].action : it.action;
        alarm_mem[slot].id     = it.alarm_id;
        alarm_mem[slot].action = act;
        alarm_mem[slot].hour   = it.alarm_hour;
        alarm_mem[slot].minute = it.alarm_minute;
        alarm_mem[slot].days   = it.day_mask;
        alarm_mem[slot].fired  = 1'b0;
        alarm_mem[slot].rpt    = it.repeat_alarm;
        alarm_mem[slot].well   = it.setting_well_formed;
        slot_taken[slot]       = 1'b1;
        events_due.push_back(make_event(EvStatus, '0, 1'b0, led, 1'b1));
      end
    end else if (it.kind == KindTick) begin
      for (int i = 0; i < Slots; i++) begin
        if (slot_taken[i]) begin
          any_used = 1'b1;
          act      = alarm_mem[i].action;
          // Actions outside add..edit sit in the table untouched.
          if (act >= ActAdd && act <= ActEdit) begin
            if (act == ActDisabled || !alarm_mem[i].well) begin
              drop_alarm(alarm_mem[i].id);
            end else begin
              if (it.now_hour == LastHour && it.now_minute == LastMinute)
                alarm_mem[i].fired = 1'b0;
              // Weekday zero matches no mask bit, so only an empty mask takes it.
              day_hit = (alarm_mem[i].days == '0);
              if (it.now_weekday != 3'd0 && alarm_mem[i].days[it.now_weekday - 3'd1])
                day_hit = 1'b1;
              if (day_hit && alarm_mem[i].hour == it.now_hour &&
                  alarm_mem[i].minute == it.now_minute && !alarm_mem[i].fired) begin
                alarm_mem[i].fired = 1'b1;
                if (it.player_free)
                  events_due.push_back(make_event(EvPlay, alarm_mem[i].id, 1'b0, LedKeep,
                                                  1'b0));
                if (!alarm_mem[i].rpt) drop_alarm(alarm_mem[i].id);
              end
            end
          end
        end
      end
      events_due.push_back(make_event(EvTick, '0, 1'b0, any_used ? LedGreen : LedOff, 1'b1));
    end
  endfunction

  function automatic item_t random_item();
    logic [127:0] raw;
    item_t        it;
    int unsigned  pick;
    raw  = {$urandom(), $urandom(), $urandom(), $urandom()};
    it   = raw[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    it.kind = (pick < 40) ? KindAdd : (pick < 50) ? KindDel : (pick < 95) ? KindTick : KindNone;
    if ($urandom_range(0, 4) != 0) it.alarm_id = id_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.action = ActAdd;
    else if (pick < 50) it.action = ActOn;
    else if (pick < 75) it.action = ActEdit;
    else if (pick < 83) it.action = ActDisabled;
    else if (pick < 91) it.action = ActDelete;
    else                it.action = 3'($urandom_range(ActEdit + 1, ActStray));
    // Mostly pooled times; the rest keep their raw bits, out of range at times.
    pick = $urandom_range(0, 3);
    if ($urandom_range(0, 9) != 0) begin
      it.alarm_hour   = hour_pool[pick];
      it.alarm_minute = minute_pool[pick];
    end
    pick = $urandom_range(0, 3);
    if ($urandom_range(0, 9) != 0) begin
      it.now_hour   = hour_pool[pick];
      it.now_minute = minute_pool[pick];
    end
    if ($urandom_range(0, 3) == 0) it.day_mask = '0;
    it.now_weekday         = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    it.setting_well_formed = ($urandom_range(0, 9) != 0);
    it.player_free         = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  // Presents one word, waits for it to be taken and books its results. A
  // typed expectation replaces what the model booked for that word.
  task automatic send_word(item_t it, bit typed, result_t want);
    int unsigned owed;
    bit          ready_seen;
    if (!calm && $urandom_range(0, 7) < idle_level * 2) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {3'b000, it.player_free, it.now_weekday, it.now_minute, it.now_hour,
                      it.setting_well_formed, it.repeat_alarm, it.day_mask, it.alarm_minute,
                      it.alarm_hour, it.action, it.alarm_id};
    // Ready is looked at mid-cycle, where it has settled; the word is taken
    // at the following rising edge.
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    owed = events_due.size();
    predict_events(it);
    if (typed) begin
      while (events_due.size() > owed) void'(events_due.pop_back());
      events_due.push_back(want);
    end
    case (it.kind)
      KindAdd: begin
        n_adds++;
      end
      KindDel: begin
        n_deletes++;
      end
      KindTick: begin
        n_ticks++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [IdW-1:0] seen, logic [IdW-1:0] wanted);
    if (n_mismatch < MaxReports)
      $display("%0t: %s differs: got %0h, expected %0h", $time, what, seen, wanted);
    n_mismatch++;
  endtask

  // Result side: ready drops in random idle bursts while calm is off.
  initial begin : sink_ready
    int unsigned hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) < idle_level * 2) begin
        hold = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Each word seen valid and ready mid-cycle is taken at the next rising edge
  // and is held stable until then, so it is compared here.
  initial begin : result_check
    result_t got;
    result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.ev         = m_axis_tuser;
        got.fired_id   = m_axis_tdata[IdW-1:0];
        got.table_full = m_axis_tdata[IdW];
        got.led        = m_axis_tdata[IdW+2:IdW+1];
        got.last       = m_axis_tlast;
        n_results++;
        if (got.ev == EvPlay) n_plays++;
        if (events_due.size() == 0) begin
          report_mismatch("word with nothing owed, event", IdW'(got.ev), '0);
        end else begin
          want = events_due.pop_front();
          if (got.ev != want.ev)                 report_mismatch("event", IdW'(got.ev),
                                                                  IdW'(want.ev));
          if (got.fired_id != want.fired_id)     report_mismatch("fired ID", got.fired_id,
                                                                  want.fired_id);
          if (got.table_full != want.table_full) report_mismatch("table full",
                                                                  IdW'(got.table_full),
                                                                  IdW'(want.table_full));
          if (got.led != want.led)               report_mismatch("indicator", IdW'(got.led),
                                                                  IdW'(want.led));
          if (got.last != want.last)             report_mismatch("last flag", IdW'(got.last),
                                                                  IdW'(want.last));
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t script [$];
    item_t       it;
    int unsigned sent;
    logic [4:0]  hh;
    logic [5:0]  mm;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KindNone;
    for (int i = 0; i < Slots; i++) begin
      alarm_mem[i]  = '0;
      slot_taken[i] = 1'b0;
    end
    id_pool[0] = '0;
    id_pool[1] = IdTop;
    for (int i = 2; i < 8; i++) id_pool[i] = fresh_id();
    // The last minute of the day and midnight are always in the pool.
    hour_pool[0]   = LastHour;
    minute_pool[0] = LastMinute;
    hour_pool[1]   = 5'd0;
    minute_pool[1] = 6'd0;
    for (int i = 2; i < 4; i++) begin
      hour_pool[i]   = 5'($urandom_range(0, 23));
      minute_pool[i] = 6'($urandom_range(0, 59));
    end

    // Directed part. Rows whose result is plain from the rules carry it;
    // the others are left to the model.
    // A tick on the empty table reports the indicator off.
    script.push_back('{tick_item(LastHour, LastMinute, 3'd7, 1'b1), 1'b1,
                       make_event(EvTick, '0, 1'b0, LedOff, 1'b1)});
    // Deleting an ID that is not stored still answers with a status word.
    script.push_back('{alarm_item(KindDel, IdTop, ActOn, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                       make_event(EvStatus, '0, 1'b0, LedOff, 1'b1)});
    // Extremes: the lowest ID at midnight, repeating, any day...
    script.push_back('{alarm_item(KindAdd, '0, ActAdd, 5'd0, 6'd0, 7'h00, 1'b1, 1'b1), 1'b1,
                       make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    // ...and the highest ID in the last minute, one-shot, every day.
    script.push_back('{alarm_item(KindAdd, IdTop, ActOn, LastHour, LastMinute, 7'h7f, 1'b0,
                                  1'b1), 1'b1, make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    // A disabled alarm leaves the indicator as it is.
    script.push_back('{alarm_item(KindAdd, 63'd5, ActDisabled, 5'd0, 6'd0, 7'h00, 1'b1, 1'b1),
                       1'b1, make_event(EvStatus, '0, 1'b0, LedKeep, 1'b1)});
    // An edit into a slot never written keeps its reset action, which is idle.
    script.push_back('{alarm_item(KindAdd, 63'd6, ActEdit, 5'd0, 6'd0, 7'h00, 1'b1, 1'b1),
                       1'b1, make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    // An action beyond the edit code is stored but never scheduled.
    script.push_back('{alarm_item(KindAdd, 63'd7, ActStray, 5'd0, 6'd0, 7'h00, 1'b1, 1'b1),
                       1'b1, make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    // A malformed setting is accepted now and dropped by the next tick.
    script.push_back('{alarm_item(KindAdd, 63'd8, ActOn, 5'd0, 6'd0, 7'h00, 1'b1, 1'b0), 1'b1,
                       make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    // Midnight fires the repeating alarm once; the second tick finds it fired.
    script.push_back('{tick_item(5'd0, 6'd0, 3'd1, 1'b1), 1'b0, '0});
    script.push_back('{tick_item(5'd0, 6'd0, 3'd1, 1'b1), 1'b0, '0});
    // The last minute clears fired marks and fires the one-shot alarm.
    script.push_back('{tick_item(LastHour, LastMinute, 3'd7, 1'b1), 1'b0, '0});
    // Weekday zero with the player busy: the empty mask fires without a play word.
    script.push_back('{tick_item(5'd0, 6'd0, 3'd0, 1'b0), 1'b0, '0});
    // A Monday-only alarm, missed on Tuesday and fired on Monday.
    script.push_back('{alarm_item(KindAdd, 63'd9, ActAdd, 5'd12, 6'd30, 7'h01, 1'b1, 1'b1),
                       1'b1, make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    script.push_back('{tick_item(5'd12, 6'd30, 3'd2, 1'b1), 1'b0, '0});
    script.push_back('{tick_item(5'd12, 6'd30, 3'd1, 1'b1), 1'b0, '0});
    // An edit keeps the stored action, moves it to Sunday and rearms it.
    script.push_back('{alarm_item(KindAdd, 63'd9, ActEdit, 5'd12, 6'd31, 7'h40, 1'b1, 1'b1),
                       1'b1, make_event(EvStatus, '0, 1'b0, LedGreen, 1'b1)});
    script.push_back('{tick_item(5'd12, 6'd31, 3'd7, 1'b1), 1'b0, '0});
    // An add with the delete action, then a plain delete.
    script.push_back('{alarm_item(KindAdd, 63'd9, ActDelete, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                       make_event(EvStatus, '0, 1'b0, LedOff, 1'b1)});
    script.push_back('{alarm_item(KindDel, '0, ActAdd, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                       make_event(EvStatus, '0, 1'b0, LedOff, 1'b1)});
    // A word of unknown kind is swallowed without a result.
    script.push_back('{alarm_item(KindNone, 63'd3, ActAdd, '0, '0, '0, 1'b1, 1'b1), 1'b0, '0});
    // A clock reading outside the day.
    script.push_back('{tick_item(5'd31, 6'd63, 3'd7, 1'b1), 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k]) send_word(script[k].it, script[k].typed, script[k].want);

    // Random part. Three times the table is filled to overflow with one-shot
    // alarms sharing a time, and a tick at that time fires them all at once.
    sent = 0;
    while (sent < RandomWords) begin
      if (sent % 25 == 0) idle_level = $urandom_range(0, 3);
      calm = (sent >= RandomWords - CalmWords);
      if (sent == 30 || sent == 120 || sent == 190) begin
        hh = 5'($urandom_range(0, 23));
        mm = 6'($urandom_range(0, 59));
        repeat (Slots + 1) begin
          it                     = random_item();
          it.kind                = KindAdd;
          it.alarm_id            = fresh_id();
          it.action              = ActAdd;
          it.alarm_hour          = hh;
          it.alarm_minute        = mm;
          it.day_mask            = '0;
          it.repeat_alarm        = 1'b0;
          it.setting_well_formed = 1'b1;
          send_word(it, 1'b0, '0);
        end
        it             = random_item();
        it.kind        = KindTick;
        it.now_hour    = hh;
        it.now_minute  = mm;
        it.player_free = 1'b1;
        send_word(it, 1'b0, '0);
        sent += Slots + 2;
      end else begin
        it = random_item();
        send_word(it, 1'b0, '0);
        if (it.kind != KindNone) sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Once nothing is owed, allow time for two more full scans before closing.
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (2 * Slots + 8) @(posedge clk_i);

    $display("Run covered %0d adds or edits, %0d deletes, %0d ticks and %0d ignored words.",
             n_adds, n_deletes, n_ticks, n_ignored);
    $display("%0d result words checked, %0d of them play requests.", n_results, n_plays);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A slow but correct run of about 280 words, each owing up to 17 results
  // that wait out stalls of the result side, needs well under a millisecond.
  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d result words outstanding.", events_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
sv/wat_pkg.sv
sv/wat_mem.sv
sv/wat_obuf.sv
sv/wat_seq.sv
sv/weekday_alarm_table.sv
test/weekday_alarm_table_tb.sv
